/* rtl/tscc_pkg.sv */
// Package with the shared types and constants of the congestion control block.
`timescale 1ns / 1ps
`default_nettype none
package tscc_pkg;

  localparam int unsigned WindowDepth = 64;
  localparam int unsigned IdxW        = $clog2(WindowDepth);
  localparam int unsigned SeqW        = 8;
  localparam int unsigned RttW        = 20;
  localparam int unsigned CwndW       = 10;

  localparam logic [CwndW-1:0] CwndMax      = 10'd1023;
  localparam logic [CwndW-1:0] CwndReset    = 10'd4;
  localparam logic [CwndW-1:0] SsthreshMin  = 10'd8;
  localparam logic [CwndW-1:0] SsthreshRst  = 10'd256;
  localparam logic [RttW-1:0]  TimeoutRst   = 20'd8000;
  localparam logic [SeqW:0]    WindowLimit  = 9'(WindowDepth);

  typedef enum logic [1:0] {
    ActSend  = 2'd0,
    ActAck   = 2'd1,
    ActTimer = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    RegRtoInitial = 3'd0,
    RegRtoMin     = 3'd1,
    RegRtoMax     = 3'd2,
    RegSrttGain   = 3'd3,
    RegVarGain    = 3'd4,
    RegVarMult    = 3'd5,
    RegSsthresh   = 3'd6,
    RegUnused     = 3'd7
  } cfg_reg_e;

  // Smoothed round trip estimate and its variance.
  typedef struct packed {
    logic [RttW-1:0] srtt;
    logic [RttW-1:0] rttvar;
  } rtt_t;

  // One window entry as held in the entry memory.
  typedef struct packed {
    logic        rtt_ok;
    logic [31:0] sent_ms;
  } entry_t;

endpackage
`default_nettype wire

/* rtl/tscc_rtt_est.sv */
// Round trip estimator update for one sample.
`timescale 1ns / 1ps
`default_nettype none
module tscc_rtt_est import tscc_pkg::*; (
  input  wire logic [31:0] now_ms_i,
  input  wire logic [31:0] sent_ms_i,
  input  wire logic        have_i,
  input  wire rtt_t        cur_i,
  input  wire logic [2:0]  srtt_gain_i,
  input  wire logic [2:0]  var_gain_i,
  output rtt_t             nxt_o
);

  logic [31:0]     diff;
  logic [RttW-1:0] sample;
  logic [RttW-1:0] dev;

  // The sample is the elapsed time in eighths, capped at the field width.
  always_comb begin
    diff   = now_ms_i - sent_ms_i;
    sample = (diff[31:RttW-3] != '0) ? {RttW{1'b1}} : {diff[RttW-4:0], 3'b000};
    dev    = (cur_i.srtt > sample) ? cur_i.srtt - sample : sample - cur_i.srtt;
    if (!have_i) begin
      nxt_o.srtt   = sample;
      nxt_o.rttvar = sample >> 1;
    end else begin
      nxt_o.rttvar = cur_i.rttvar - (cur_i.rttvar >> var_gain_i) + (dev >> var_gain_i);
      nxt_o.srtt   = cur_i.srtt - (cur_i.srtt >> srtt_gain_i) + (sample >> srtt_gain_i);
    end
  end

endmodule
`default_nettype wire

/* rtl/tcp_sender_window_congestion_control.sv */
// Top level of the sender window and congestion control block.
`timescale 1ns / 1ps
`default_nettype none
// Sender window and congestion control. Each input transaction carries an
// action (send, ack, timer check) and a millisecond time, and yields exactly
// one result transaction. A send, a duplicate ack, an ack outside the window
// and the unused action go from the execute state straight to the done
// state. An ack inside the window walks the release state over each
// released entry, passes the multiply state when a round trip sample was
// taken, then the clamp state. A timer check walks the entries in flight
// until one has expired or the walk ends. Each walk reads the entry memory
// through its single read port; it holds send times and sample flags.
// The next transaction is accepted while a result still waits at the output.
// Configuration is to be written only while the block is idle; the block
// itself does not enforce it. The initial timeout and initial threshold
// registers act through their reset values.
module tcp_sender_window_congestion_control import tscc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  ack_number_i,
  input  wire logic [31:0] now_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             send_granted_o,
  output logic [7:0]       send_seqno_o,
  output logic             retransmit_o,
  output logic [7:0]       retransmit_seqno_o,
  output logic [6:0]       released_count_o,
  output logic [9:0]       cwnd_quarters_o,
  output logic [18:0]      rto_eighths_ms_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StExec   = 7'b0000010,
    StAwalk  = 7'b0000100,
    StTwalk  = 7'b0001000,
    StTmul   = 7'b0010000,
    StTclamp = 7'b0100000,
    StDone   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] rto_min_q, rto_max_q;
  logic [2:0]  srtt_gain_q, var_gain_q;
  logic [3:0]  var_mult_q;

  // Control state.
  logic [WindowDepth-1:0] valid_q;
  logic [SeqW-1:0]  next_seq_q, oldest_q, prev_ack_q;
  logic [1:0]       dup_q;
  logic [CwndW-1:0] cwnd_q, ssthresh_q;
  rtt_t             rtt_q;
  logic             have_q;
  logic [RttW-1:0]  timeout_q;

  // Current transaction.
  action_e          action_q;
  logic [SeqW-1:0]  ack_q;
  logic [31:0]      now_q;
  logic [SeqW-1:0]  walk_q;
  logic             pend_q;
  logic [SeqW-1:0]  pend_seq_q;
  logic             sampled_q;
  logic [23:0]      prod_q;
  logic             granted_q, retx_q;
  logic [SeqW-1:0]  gseq_q, rseq_q;
  logic [6:0]       released_q;

  // Output register.
  logic             out_valid_q;
  logic             o_granted_q, o_retx_q;
  logic [SeqW-1:0]  o_gseq_q, o_rseq_q;
  logic [6:0]       o_released_q;
  logic [CwndW-1:0] o_cwnd_q;
  logic [18:0]      o_rto_q;

  // Entry memory.
  entry_t           mem_q [WindowDepth];
  entry_t           rd_q;
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_waddr, mem_raddr;
  entry_t           mem_wdata;

  logic [SeqW-1:0]  inflight, ack_off, walk_seq;
  logic [18:0]      hi_lim, lo_lim;
  logic [20:0]      dbl_to;
  logic [21:0]      sesqui_to;
  logic [RttW-1:0]  dbl_clamped, sesqui_clamped;
  logic [CwndW-1:0] half_cwnd, ssthresh_collapse;
  logic [24:0]      tsum, tlo;
  logic [RttW-1:0]  tnew;
  logic [10:0]      cwnd_sum;
  logic [31:0]      elapsed;
  logic [34:0]      elapsed8;
  logic             expired;
  logic             can_send, out_free;
  rtt_t             rtt_nxt;

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  // Combinational helpers shared by several actions.
  always_comb begin
    inflight          = next_seq_q - oldest_q;
    ack_off           = ack_q - oldest_q;
    walk_seq          = oldest_q + walk_q;
    hi_lim            = {rto_max_q, 3'b000};
    lo_lim            = {rto_min_q, 3'b000};
    dbl_to            = {timeout_q, 1'b0};
    sesqui_to         = ({1'b0, timeout_q, 1'b0} + {2'b00, timeout_q}) >> 1;
    dbl_clamped       = (dbl_to > {2'b00, hi_lim}) ? {1'b0, hi_lim} : dbl_to[RttW-1:0];
    sesqui_clamped    = (sesqui_to > {3'b000, hi_lim}) ? {1'b0, hi_lim}
                                                       : sesqui_to[RttW-1:0];
    half_cwnd         = cwnd_q >> 1;
    ssthresh_collapse = (half_cwnd < SsthreshMin) ? SsthreshMin : half_cwnd;
    tsum              = {5'b0, rtt_q.srtt} + {1'b0, prod_q};
    tlo               = (tsum < {6'b0, lo_lim}) ? {6'b0, lo_lim} : tsum;
    tnew              = (tlo > {6'b0, hi_lim}) ? {1'b0, hi_lim} : tlo[RttW-1:0];
    cwnd_sum          = {1'b0, cwnd_q} + ((cwnd_q < ssthresh_q) ? 11'd4 : 11'd2);
    elapsed           = now_q - rd_q.sent_ms;
    elapsed8          = {elapsed, 3'b000};
    expired           = (elapsed8 >= {15'b0, timeout_q});
    can_send          = ({1'b0, inflight} < {1'b0, cwnd_q[CwndW-1:2]}) &&
                        ({1'b0, inflight} < WindowLimit) &&
                        (inflight != {SeqW{1'b1}});
  end

  tscc_rtt_est u_rtt_est (
    .now_ms_i    (now_q),
    .sent_ms_i   (rd_q.sent_ms),
    .have_i      (have_q),
    .cur_i       (rtt_q),
    .srtt_gain_i (srtt_gain_q),
    .var_gain_i  (var_gain_q),
    .nxt_o       (rtt_nxt)
  );

  // Entry memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = walk_q[IdxW-1:0];
    unique case (state_q)
      StExec: begin
        if (action_q == ActSend && can_send) begin
          mem_we    = 1'b1;
          mem_waddr = next_seq_q[IdxW-1:0];
          mem_wdata = '{rtt_ok: 1'b1, sent_ms: now_q};
        end else if (action_q == ActAck && ack_q == prev_ack_q && dup_q == 2'd2 &&
                     ack_off < inflight && valid_q[ack_q[IdxW-1:0]]) begin
          mem_we    = 1'b1;
          mem_waddr = ack_q[IdxW-1:0];
          mem_wdata = '{rtt_ok: 1'b0, sent_ms: now_q};
        end
      end
      StAwalk: begin
        mem_re    = (oldest_q != ack_q);
        mem_raddr = oldest_q[IdxW-1:0];
      end
      StTwalk: begin
        if (pend_q && expired) begin
          mem_we    = 1'b1;
          mem_waddr = pend_seq_q[IdxW-1:0];
          mem_wdata = '{rtt_ok: 1'b0, sent_ms: now_q};
        end else begin
          mem_re    = (walk_q != inflight);
          mem_raddr = walk_seq[IdxW-1:0];
        end
      end
      StIdle, StTmul, StTclamp, StDone: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rto_min_q   <= 16'd100;
      rto_max_q   <= 16'd60000;
      srtt_gain_q <= 3'd3;
      var_gain_q  <= 3'd2;
      var_mult_q  <= 4'd4;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRtoMin:   rto_min_q   <= cfg_data_i;
        RegRtoMax:   rto_max_q   <= cfg_data_i;
        RegSrttGain: srtt_gain_q <= cfg_data_i[2:0];
        RegVarGain:  var_gain_q  <= cfg_data_i[2:0];
        RegVarMult:  var_mult_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i) state_d = StExec;
      StExec: begin
        state_d = StDone;
        if (action_q == ActAck && ack_q != prev_ack_q && ack_off <= inflight) begin
          state_d = StAwalk;
        end else if (action_q == ActTimer) begin
          state_d = StTwalk;
        end
      end
      StAwalk: begin
        if (oldest_q == ack_q && !pend_q) begin
          state_d = (sampled_q || (pend_q && rd_q.rtt_ok)) ? StTmul : StTclamp;
        end
      end
      StTwalk: begin
        if ((pend_q && expired) || (walk_q == inflight && !pend_q)) state_d = StDone;
      end
      StTmul:   state_d = StTclamp;
      StTclamp: state_d = StDone;
      StDone:   if (out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Sequencer datapath and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      valid_q      <= '0;
      next_seq_q   <= '0;
      oldest_q     <= '0;
      prev_ack_q   <= '0;
      dup_q        <= '0;
      cwnd_q       <= CwndReset;
      ssthresh_q   <= SsthreshRst;
      rtt_q        <= '0;
      have_q       <= 1'b0;
      timeout_q    <= TimeoutRst;
      pend_q       <= 1'b0;
      sampled_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      action_q     <= ActNone;
      ack_q        <= '0;
      now_q        <= '0;
      walk_q       <= '0;
      pend_seq_q   <= '0;
      prod_q       <= '0;
      granted_q    <= 1'b0;
      retx_q       <= 1'b0;
      gseq_q       <= '0;
      rseq_q       <= '0;
      released_q   <= '0;
      o_granted_q  <= 1'b0;
      o_retx_q     <= 1'b0;
      o_gseq_q     <= '0;
      o_rseq_q     <= '0;
      o_released_q <= '0;
      o_cwnd_q     <= '0;
      o_rto_q      <= '0;
    end else begin
      state_q <= state_d;
      // The output register fills from the done state and empties on acceptance.
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            action_q   <= action_e'(action_i);
            ack_q      <= ack_number_i;
            now_q      <= now_ms_i;
            granted_q  <= 1'b0;
            retx_q     <= 1'b0;
            gseq_q     <= '0;
            rseq_q     <= '0;
            released_q <= '0;
            walk_q     <= '0;
            pend_q     <= 1'b0;
            sampled_q  <= 1'b0;
          end
        end
        StExec: begin
          case (action_q)
            ActSend: begin
              if (can_send) begin
                valid_q[next_seq_q[IdxW-1:0]] <= 1'b1;
                granted_q  <= 1'b1;
                gseq_q     <= next_seq_q;
                next_seq_q <= next_seq_q + 8'd1;
              end
            end
            ActAck: begin
              if (ack_q == prev_ack_q) begin
                // Third duplicate: collapse the window and back off.
                if (dup_q == 2'd2) begin
                  dup_q      <= '0;
                  ssthresh_q <= ssthresh_collapse;
                  cwnd_q     <= CwndReset;
                  timeout_q  <= dbl_clamped;
                  if (ack_off < inflight && valid_q[ack_q[IdxW-1:0]]) begin
                    retx_q <= 1'b1;
                    rseq_q <= ack_q;
                  end
                end else begin
                  dup_q <= dup_q + 2'd1;
                end
              end else begin
                dup_q      <= '0;
                prev_ack_q <= ack_q;
              end
            end
            default: ;
          endcase
        end
        StAwalk: begin
          // Sample stage for the entry read in the previous cycle.
          if (pend_q && rd_q.rtt_ok) begin
            rtt_q     <= rtt_nxt;
            have_q    <= 1'b1;
            sampled_q <= 1'b1;
          end
          // Release stage: one entry a cycle.
          if (oldest_q != ack_q) begin
            pend_q                      <= valid_q[oldest_q[IdxW-1:0]];
            valid_q[oldest_q[IdxW-1:0]] <= 1'b0;
            released_q                  <= released_q + 7'd1;
            oldest_q                    <= oldest_q + 8'd1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              cwnd_q <= (cwnd_sum > {1'b0, CwndMax}) ? CwndMax : cwnd_sum[CwndW-1:0];
            end
          end
        end
        StTwalk: begin
          if (pend_q && expired) begin
            ssthresh_q <= ssthresh_collapse;
            cwnd_q     <= CwndReset;
            timeout_q  <= sesqui_clamped;
            retx_q     <= 1'b1;
            rseq_q     <= pend_seq_q;
            pend_q     <= 1'b0;
          end else if (walk_q != inflight) begin
            pend_q     <= valid_q[walk_seq[IdxW-1:0]];
            pend_seq_q <= walk_seq;
            walk_q     <= walk_q + 8'd1;
          end else begin
            pend_q <= 1'b0;
          end
        end
        StTmul: prod_q <= {20'b0, var_mult_q} * {4'b0, rtt_q.rttvar};
        StTclamp: begin
          if (sampled_q) timeout_q <= tnew;
        end
        StDone: begin
          if (out_free) begin
            o_granted_q  <= granted_q;
            o_retx_q     <= retx_q;
            o_gseq_q     <= gseq_q;
            o_rseq_q     <= rseq_q;
            o_released_q <= released_q;
            o_cwnd_q     <= cwnd_q;
            o_rto_q      <= timeout_q[18:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign send_granted_o     = o_granted_q;
  assign send_seqno_o       = o_gseq_q;
  assign retransmit_o       = o_retx_q;
  assign retransmit_seqno_o = o_rseq_q;
  assign released_count_o   = o_released_q;
  assign cwnd_quarters_o    = o_cwnd_q;
  assign rto_eighths_ms_o   = o_rto_q;

  // A result never both grants a send and asks for a resend.
  a_grant_xor_retx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(send_granted_o && retransmit_o))
    else $error("grant and retransmit in one result");

  // The window never drops below one packet.
  a_cwnd_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cwnd_q >= CwndReset)
    else $error("congestion window below one packet");

  // Packets in flight never exceed the window depth.
  a_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, inflight} <= WindowLimit)
    else $error("in-flight count beyond window depth");

  // Released entries come only with a transaction that neither sends nor resends.
  a_release_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && released_count_o != '0) |-> (!send_granted_o && !retransmit_o))
    else $error("release reported with send or resend");

endmodule
`default_nettype wire
